// ===== hdl/bivariate_gaussian_density_unit_macros.svh =====
// assertion macros used by the checker file
`ifndef BIVARIATE_GAUSSIAN_DENSITY_UNIT_MACROS_SVH
`define BIVARIATE_GAUSSIAN_DENSITY_UNIT_MACROS_SVH

// same-cycle implication
`define BGD_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("bgd assertion failed");

// next-cycle implication
`define BGD_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("bgd assertion failed");

`endif

// ===== hdl/bgd_pkg.sv =====
// types and constants of the bivariate gaussian density unit
`default_nettype none
package bgd_pkg;

   localparam int unsigned ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_CENTER_PHI      = 3'd0,
      REG_CENTER_THETA    = 3'd1,
      REG_WEIGHT_PHI_SQ   = 3'd2,
      REG_WEIGHT_THETA_SQ = 3'd3,
      REG_WEIGHT_CROSS    = 3'd4,
      REG_EXPONENT_SCALE  = 3'd5,
      REG_NORM_SCALE      = 3'd6
   } reg_index_type;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam int unsigned TAYLOR_N  = 9;

   localparam logic [31:0] INV_FACT_Q30 [0:9] = '{
      32'd1073741824, 32'd1073741824, 32'd536870912, 32'd178956971, 32'd44739243,
      32'd8947849, 32'd1491308, 32'd213044, 32'd26631, 32'd2959
   };

   typedef struct packed {
      logic signed [25:0] center_phi;
      logic signed [25:0] center_theta;
      logic [31:0]        weight_phi_sq;
      logic [31:0]        weight_theta_sq;
      logic signed [31:0] weight_cross;
      logic signed [31:0] exponent_scale;
      logic [31:0]        norm_scale;
   } cfg_type;

   // valid bit and batch marker that ride with each word
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   // range flags of the exponent
   typedef struct packed {
      logic under;
      logic over;
   } range_type;

endpackage
`default_nettype wire

// ===== hdl/bgd_quad.sv =====
// offsets, quadratic form and exponent scaling, five stages
`default_nettype none
module bgd_quad (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire bgd_pkg::cfg_type   cfg,
   input  wire bgd_pkg::tag_type   in_tag,
   input  wire logic signed [25:0] phi,
   input  wire logic signed [25:0] theta,
   output bgd_pkg::tag_type        out_tag,
   output logic signed [47:0]      z
);
   import bgd_pkg::*;

   localparam logic signed [57:0] Q_MAX = 58'sh7FFFFFFF;
   localparam logic signed [57:0] Q_MIN = -58'sh80000000;

   tag_type tag_ff [1:5];

   logic signed [26:0] d1_ff, d2_ff;
   logic signed [37:0] s11_ff, s22_ff, s12_ff;
   logic signed [54:0] a11_ff, b11_ff, a22_ff, b22_ff, a12_ff, b12_ff;
   logic signed [31:0] q_ff;
   logic signed [47:0] z_ff;

   logic signed [53:0] p11_in, p22_in, p12_in;
   logic signed [32:0] w11, w22, w12;
   logic signed [55:0] t11, t22, t12;
   logic signed [57:0] q_sum;
   logic signed [31:0] q_in;
   logic signed [63:0] zp_in;

   always_comb begin
      p11_in = d1_ff * d1_ff;
      p22_in = d2_ff * d2_ff;
      p12_in = d1_ff * d2_ff;
      w11 = $signed({1'b0, cfg.weight_phi_sq});
      w22 = $signed({1'b0, cfg.weight_theta_sq});
      w12 = 33'(cfg.weight_cross);
      // floor(s*w/2^16) = s*hi + floor(s*lo/2^16)
      t11 = 56'(a11_ff) + 56'(b11_ff >>> 16);
      t22 = 56'(a22_ff) + 56'(b22_ff >>> 16);
      t12 = 56'(a12_ff) + 56'(b12_ff >>> 16);
      q_sum = 58'(t11) - 58'(t12) + 58'(t22);
      if (q_sum > Q_MAX) begin
         q_in = 32'sh7FFFFFFF;
      end else if (q_sum < Q_MIN) begin
         q_in = -32'sh80000000;
      end else begin
         q_in = q_sum[31:0];
      end
      zp_in = q_ff * cfg.exponent_scale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= 5; i++) tag_ff[i] <= '0;
      end else if (en) begin
         tag_ff[1] <= in_tag;
         for (int i = 2; i <= 5; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= 27'(phi) - 27'(cfg.center_phi);
         d2_ff  <= 27'(theta) - 27'(cfg.center_theta);
         s11_ff <= p11_in[53:16];
         s22_ff <= p22_in[53:16];
         s12_ff <= p12_in[53:16];
         a11_ff <= s11_ff * $signed(w11[32:16]);
         b11_ff <= s11_ff * $signed({1'b0, w11[15:0]});
         a22_ff <= s22_ff * $signed(w22[32:16]);
         b22_ff <= s22_ff * $signed({1'b0, w22[15:0]});
         a12_ff <= s12_ff * $signed(w12[32:16]);
         b12_ff <= s12_ff * $signed({1'b0, w12[15:0]});
         q_ff   <= q_in;
         z_ff   <= zp_in[63:16];
      end
   end

   assign out_tag = tag_ff[5];
   assign z       = z_ff;
endmodule
`default_nettype wire

// ===== hdl/bgd_exp.sv =====
// base-2 split and taylor chain of exp(z), one horner step per stage
`default_nettype none
module bgd_exp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire bgd_pkg::tag_type   in_tag,
   input  wire logic signed [47:0] z,
   output bgd_pkg::tag_type        out_tag,
   output bgd_pkg::range_type      out_range,
   output logic signed [7:0]       n,
   output logic [31:0]             e
);
   import bgd_pkg::*;

   localparam logic signed [47:0] Z_LOW  = -48'sd1572864;
   localparam logic signed [47:0] Z_HIGH = 48'sd1507328;
   localparam int unsigned LAST = TAYLOR_N + 1;

   tag_type            tag_ff   [0:LAST];
   range_type          range_ff [0:LAST];
   logic signed [7:0]  n_ff     [1:LAST];
   logic [29:0]        t_ff     [1:LAST];
   logic [31:0]        e_ff     [1:LAST];
   logic signed [53:0] y_ff;

   logic signed [37:0] y;
   logic [59:0]        t_prod;

   always_comb begin
      y      = y_ff[53:16];
      t_prod = y[29:0] * LN2_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) tag_ff[i] <= '0;
      end else if (en) begin
         tag_ff[0] <= in_tag;
         for (int i = 1; i <= LAST; i++) tag_ff[i] <= tag_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         range_ff[0].under <= z < Z_LOW;
         range_ff[0].over  <= z >= Z_HIGH;
         y_ff        <= $signed(z[21:0]) * $signed({1'b0, LOG2E_Q30});
         range_ff[1] <= range_ff[0];
         n_ff[1]     <= y[37:30];
         t_ff[1]     <= t_prod[59:30];
         e_ff[1]     <= INV_FACT_Q30[TAYLOR_N];
      end
   end

   for (genvar k = 2; k <= LAST; k++) begin : g_horner
      logic [61:0] et;
      assign et = e_ff[k-1] * t_ff[k-1];
      always_ff @(posedge clock) begin
         if (en) begin
            range_ff[k] <= range_ff[k-1];
            n_ff[k]     <= n_ff[k-1];
            t_ff[k]     <= t_ff[k-1];
            e_ff[k]     <= INV_FACT_Q30[LAST-k] + et[61:30];
         end
      end
   end

   assign out_tag   = tag_ff[LAST];
   assign out_range = range_ff[LAST];
   assign n         = n_ff[LAST];
   assign e         = e_ff[LAST];
endmodule
`default_nettype wire

// ===== hdl/bgd_scale.sv =====
// normalisation multiply, power-of-two shift with rounding, saturation
`default_nettype none
module bgd_scale (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic [31:0]         norm_scale,
   input  wire bgd_pkg::tag_type    in_tag,
   input  wire bgd_pkg::range_type  in_range,
   input  wire logic signed [7:0]   n,
   input  wire logic [31:0]         e,
   output bgd_pkg::tag_type         out_tag,
   output logic [31:0]              density
);
   import bgd_pkg::*;

   localparam logic [31:0] SAT = 32'hFFFFFFFF;

   tag_type           tag_ff [1:2];
   range_type         range_ff;
   logic [63:0]       m_ff;
   logic signed [7:0] sh_ff;
   logic [31:0]       density_ff;

   logic [64:0] rsum;
   logic [64:0] rshift;
   logic [2:0]  lk;
   logic [31:0] d_in;

   always_comb begin
      rsum   = {1'b0, m_ff} + (65'd1 << (sh_ff[6:0] - 7'd1));
      rshift = rsum >> sh_ff[6:0];
      lk     = 3'(-sh_ff);
      if (range_ff.under) begin
         d_in = '0;
      end else if (range_ff.over) begin
         d_in = (norm_scale != '0) ? SAT : '0;
      end else if (sh_ff >= 8'sd64) begin
         d_in = '0;
      end else if (sh_ff > 8'sd0) begin
         d_in = (rshift > 65'(SAT)) ? SAT : rshift[31:0];
      end else if (m_ff > (64'(SAT) >> lk)) begin
         d_in = SAT;
      end else begin
         d_in = m_ff[31:0] << lk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff[1] <= '0;
         tag_ff[2] <= '0;
      end else if (en) begin
         tag_ff[1] <= in_tag;
         tag_ff[2] <= tag_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         range_ff   <= in_range;
         m_ff       <= norm_scale * e;
         sh_ff      <= 8'sd30 - n;
         density_ff <= d_in;
      end
   end

   assign out_tag = tag_ff[2];
   assign density = density_ff;
endmodule
`default_nettype wire

// ===== hdl/bivariate_gaussian_density_unit.sv =====
// bivariate gaussian density unit, top level
//
//  channel   direction  content
//  req_      in         sample point: phi, theta, batch end
//  rsp_      out        density and batch end
//  csr_      in/out     register access
//
// one word enters per clock while the rsp_ channel is not stalled
// the pipeline holds the nine-step taylor chain plus the multiply stages
// a stalled rsp_ channel holds every stage in place; a free slot at the
// output lets req_ keep flowing
// reset clears the valid bits and restores the register values
`default_nettype none
module bivariate_gaussian_density_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [55:0]                req_tdata,  // phi_sample, theta_sample, pad
   input  wire logic                       req_tlast,  // final_point
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [31:0]                     rsp_tdata,  // density
   output logic                            rsp_tlast,  // final_result
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [bgd_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import bgd_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type widx;
   logic          en;
   tag_type       in_tag, quad_tag, exp_tag, out_tag;
   range_type     exp_range;
   logic signed [47:0] z;
   logic signed [7:0]  n;
   logic [31:0]        e;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign in_tag     = '{valid: req_tvalid, last: req_tlast};
   assign widx       = reg_index_type'(csr_paddr[4:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_phi      <= '0;
         cfg_ff.center_theta    <= '0;
         cfg_ff.weight_phi_sq   <= 32'd65536;
         cfg_ff.weight_theta_sq <= 32'd65536;
         cfg_ff.weight_cross    <= '0;
         cfg_ff.exponent_scale  <= -32'sd32768;
         cfg_ff.norm_scale      <= 32'd10430;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         case (widx)
            REG_CENTER_PHI:      cfg_ff.center_phi      <= csr_pwdata[25:0];
            REG_CENTER_THETA:    cfg_ff.center_theta    <= csr_pwdata[25:0];
            REG_WEIGHT_PHI_SQ:   cfg_ff.weight_phi_sq   <= csr_pwdata;
            REG_WEIGHT_THETA_SQ: cfg_ff.weight_theta_sq <= csr_pwdata;
            REG_WEIGHT_CROSS:    cfg_ff.weight_cross    <= csr_pwdata;
            REG_EXPONENT_SCALE:  cfg_ff.exponent_scale  <= csr_pwdata;
            REG_NORM_SCALE:      cfg_ff.norm_scale      <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_CENTER_PHI:      csr_prdata = 32'(cfg_ff.center_phi);
         REG_CENTER_THETA:    csr_prdata = 32'(cfg_ff.center_theta);
         REG_WEIGHT_PHI_SQ:   csr_prdata = cfg_ff.weight_phi_sq;
         REG_WEIGHT_THETA_SQ: csr_prdata = cfg_ff.weight_theta_sq;
         REG_WEIGHT_CROSS:    csr_prdata = cfg_ff.weight_cross;
         REG_EXPONENT_SCALE:  csr_prdata = cfg_ff.exponent_scale;
         REG_NORM_SCALE:      csr_prdata = cfg_ff.norm_scale;
         default:             csr_prdata = '0;
      endcase
   end

   bgd_quad u_quad (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .cfg     (cfg_ff),
      .in_tag  (in_tag),
      .phi     ($signed(req_tdata[25:0])),
      .theta   ($signed(req_tdata[51:26])),
      .out_tag (quad_tag),
      .z       (z)
   );

   bgd_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_tag    (quad_tag),
      .z         (z),
      .out_tag   (exp_tag),
      .out_range (exp_range),
      .n         (n),
      .e         (e)
   );

   bgd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .norm_scale (cfg_ff.norm_scale),
      .in_tag     (exp_tag),
      .in_range   (exp_range),
      .n          (n),
      .e          (e),
      .out_tag    (out_tag),
      .density    (rsp_tdata)
   );

   assign rsp_tvalid = out_tag.valid;
   assign rsp_tlast  = out_tag.last;
endmodule
`default_nettype wire

// ===== hdl/bgd_checker.sv =====
// port checker for the density unit and its bind
`default_nettype none
`include "bivariate_gaussian_density_unit_macros.svh"
module bgd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_pready
);
   `BGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `BGD_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_tvalid)
   `BGD_ASSERT_NOW(a_ready_when_free, clock, reset, !rsp_tvalid || rsp_tready, req_tready)
   `BGD_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_pready)
endmodule

bind bivariate_gaussian_density_unit bgd_checker u_bgd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);
`default_nettype wire
